// ----- sv/radar_frame_parser_unit_macros.svh -----
// ------------------------------------------------------------------
// radar frame parser assertion macros
// shared concurrent check forms for the parser checker
// ------------------------------------------------------------------
`ifndef RADAR_FRAME_PARSER_UNIT_MACROS_SVH
`define RADAR_FRAME_PARSER_UNIT_MACROS_SVH

// same-cycle implication, off while reset is held
`define RFP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("parser check failed: same-cycle implication");

// next-cycle implication, off while reset is held
`define RFP_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("parser check failed: next-cycle implication");

`endif

// ----- sv/rfp_pkg.sv -----
// ------------------------------------------------------------------
// rfp_pkg
// shared constants and types of the radar frame parser
// ------------------------------------------------------------------
`default_nettype none

package rfp_pkg;

  // frame marker bytes
  localparam logic [7:0] SYNC_A = 8'h53;
  localparam logic [7:0] SYNC_B = 8'h59;
  localparam logic [7:0] END_A  = 8'h54;
  localparam logic [7:0] END_B  = 8'h43;

  // control / command pairs
  localparam logic [7:0] CTRL_DIST   = 8'h80;
  localparam logic [7:0] CMD_DIST    = 8'h04;
  localparam logic [7:0] CTRL_HEART  = 8'h85;
  localparam logic [7:0] CMD_HEART   = 8'h02;
  localparam logic [7:0] CTRL_BREATH = 8'h81;
  localparam logic [7:0] CMD_BRATE   = 8'h03;
  localparam logic [7:0] CMD_BVAL    = 8'h02;

  // queue between parser and value update
  localparam int CMD_DEPTH = 4;
  localparam int CMD_AW    = $clog2(CMD_DEPTH);

  // which value register a finished frame writes
  typedef enum logic [2:0] {
    UPD_NONE  = 3'd0,
    UPD_DIST  = 3'd1,
    UPD_HEART = 3'd2,
    UPD_BRATE = 3'd3,
    UPD_BVAL  = 3'd4
  } upd_kind_t;

  // one classified word from the parser
  typedef struct packed {
    logic        done;
    upd_kind_t   kind;
    logic [15:0] data;
  } cmd_entry_t;

  // one result word
  typedef struct packed {
    logic [15:0] distance;
    logic [7:0]  pulse_rate;
    logic [7:0]  breath_rate;
    logic [7:0]  breath_value;
    logic        frame_done;
  } result_t;

endpackage

`default_nettype wire

// ----- sv/rfp_front.sv -----
// ------------------------------------------------------------------
// rfp_front
// byte-serial frame parser; classifies each word into an update entry
// ------------------------------------------------------------------
`default_nettype none

module rfp_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_push,
  input  wire logic [7:0]         in_rx_byte,
  input  wire logic               cmd_full,
  output logic                    cmd_push,
  output rfp_pkg::cmd_entry_t     cmd_entry
);

  typedef enum logic [9:0] {
    PH_SYNC1 = 10'b00_0000_0001,
    PH_SYNC2 = 10'b00_0000_0010,
    PH_CTRL  = 10'b00_0000_0100,
    PH_CMD   = 10'b00_0000_1000,
    PH_LENH  = 10'b00_0001_0000,
    PH_LENL  = 10'b00_0010_0000,
    PH_DATA  = 10'b00_0100_0000,
    PH_CHK   = 10'b00_1000_0000,
    PH_END1  = 10'b01_0000_0000,
    PH_END2  = 10'b10_0000_0000
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [7:0]  ctrl_r, ctrl_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [15:0] left_r, left_nxt;
  logic [7:0]  tail0_r, tail0_nxt;
  logic [7:0]  tail1_r, tail1_nxt;
  logic [15:0] left_dec;
  logic [15:0] len_full;
  logic        accept;

  assign accept   = in_push & ~cmd_full;
  assign cmd_push = accept;
  assign left_dec = left_r - 16'd1;
  assign len_full = {left_r[15:8], in_rx_byte};

  // parser state update and classification
  always_comb begin
    phase_nxt = phase_r;
    sum_nxt   = sum_r;
    ctrl_nxt  = ctrl_r;
    cmd_nxt   = cmd_r;
    left_nxt  = left_r;
    tail0_nxt = tail0_r;
    tail1_nxt = tail1_r;
    cmd_entry.done = 1'b0;
    cmd_entry.kind = rfp_pkg::UPD_NONE;
    cmd_entry.data = {tail1_r, tail0_r};
    if (accept) begin
      unique case (phase_r)
        PH_SYNC2: begin
          if (in_rx_byte == rfp_pkg::SYNC_B) begin
            sum_nxt   = sum_r + in_rx_byte;
            phase_nxt = PH_CTRL;
          end else begin
            phase_nxt = PH_SYNC1;
          end
        end
        PH_CTRL: begin
          sum_nxt   = sum_r + in_rx_byte;
          ctrl_nxt  = in_rx_byte;
          phase_nxt = PH_CMD;
        end
        PH_CMD: begin
          sum_nxt   = sum_r + in_rx_byte;
          cmd_nxt   = in_rx_byte;
          phase_nxt = PH_LENH;
        end
        PH_LENH: begin
          sum_nxt   = sum_r + in_rx_byte;
          left_nxt  = {in_rx_byte, 8'h00};
          phase_nxt = PH_LENL;
        end
        PH_LENL: begin
          sum_nxt   = sum_r + in_rx_byte;
          left_nxt  = len_full;
          phase_nxt = (len_full == 16'd0) ? PH_CHK : PH_DATA;
        end
        PH_DATA: begin
          sum_nxt  = sum_r + in_rx_byte;
          left_nxt = left_dec;
          // keep only the last two payload bytes
          if (left_dec[15:1] == 15'd0) begin
            if (left_dec[0]) begin
              tail1_nxt = in_rx_byte;
            end else begin
              tail0_nxt = in_rx_byte;
            end
          end
          if (left_dec == 16'd0) begin
            phase_nxt = PH_CHK;
          end
        end
        PH_CHK: begin
          phase_nxt = (in_rx_byte == sum_r) ? PH_END1 : PH_SYNC1;
        end
        PH_END1: begin
          phase_nxt = (in_rx_byte == rfp_pkg::END_A) ? PH_END2 : PH_SYNC1;
        end
        PH_END2: begin
          if (in_rx_byte == rfp_pkg::END_B) begin
            cmd_entry.done = 1'b1;
            if (ctrl_r == rfp_pkg::CTRL_DIST && cmd_r == rfp_pkg::CMD_DIST) begin
              cmd_entry.kind = rfp_pkg::UPD_DIST;
            end else if (ctrl_r == rfp_pkg::CTRL_HEART && cmd_r == rfp_pkg::CMD_HEART) begin
              cmd_entry.kind = rfp_pkg::UPD_HEART;
            end else if (ctrl_r == rfp_pkg::CTRL_BREATH && cmd_r == rfp_pkg::CMD_BRATE) begin
              cmd_entry.kind = rfp_pkg::UPD_BRATE;
            end else if (ctrl_r == rfp_pkg::CTRL_BREATH && cmd_r == rfp_pkg::CMD_BVAL) begin
              cmd_entry.kind = rfp_pkg::UPD_BVAL;
            end
          end
          phase_nxt = PH_SYNC1;
        end
        default: begin
          // frame start hunt: clear the frame context on every word
          tail0_nxt = 8'h00;
          tail1_nxt = 8'h00;
          ctrl_nxt  = 8'h00;
          cmd_nxt   = 8'h00;
          left_nxt  = 16'd0;
          if (in_rx_byte == rfp_pkg::SYNC_A) begin
            sum_nxt   = in_rx_byte;
            phase_nxt = PH_SYNC2;
          end else begin
            sum_nxt   = 8'h00;
            phase_nxt = PH_SYNC1;
          end
        end
      endcase
    end
  end

  // parser registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SYNC1;
      sum_r   <= 8'h00;
      ctrl_r  <= 8'h00;
      cmd_r   <= 8'h00;
      left_r  <= 16'd0;
      tail0_r <= 8'h00;
      tail1_r <= 8'h00;
    end else begin
      phase_r <= phase_nxt;
      sum_r   <= sum_nxt;
      ctrl_r  <= ctrl_nxt;
      cmd_r   <= cmd_nxt;
      left_r  <= left_nxt;
      tail0_r <= tail0_nxt;
      tail1_r <= tail1_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- sv/rfp_cmd_fifo.sv -----
// ------------------------------------------------------------------
// rfp_cmd_fifo
// short queue of classified words between parser and value update
// ------------------------------------------------------------------
`default_nettype none

module rfp_cmd_fifo (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire rfp_pkg::cmd_entry_t entry_in,
  output logic                     full,
  input  wire logic                pop,
  output rfp_pkg::cmd_entry_t      entry_out,
  output logic                     empty
);

  rfp_pkg::cmd_entry_t            slot_r [rfp_pkg::CMD_DEPTH];
  logic [rfp_pkg::CMD_AW-1:0]     wr_r, rd_r;
  logic [rfp_pkg::CMD_AW:0]       cnt_r, cnt_nxt;
  logic                           do_push, do_pop;

  assign full      = (cnt_r == (rfp_pkg::CMD_AW + 1)'(rfp_pkg::CMD_DEPTH));
  assign empty     = (cnt_r == '0);
  assign do_push   = push & ~full;
  assign do_pop    = pop & ~empty;
  assign entry_out = slot_r[rd_r];

  // occupancy
  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  // pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (do_pop) begin
        rd_r <= rd_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_r] <= entry_in;
    end
  end

endmodule

`default_nettype wire

// ----- sv/rfp_back.sv -----
// ------------------------------------------------------------------
// rfp_back
// applies frame updates to the value registers and queues results
// ------------------------------------------------------------------
`default_nettype none

module rfp_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire rfp_pkg::cmd_entry_t cmd_entry,
  input  wire logic                cmd_empty,
  output logic                     cmd_pop,
  input  wire logic                out_pop,
  output logic                     out_empty,
  output rfp_pkg::result_t         out_res
);

  logic [15:0]       dist_r, dist_nxt;
  logic [7:0]        heart_r, heart_nxt;
  logic [7:0]        brate_r, brate_nxt;
  logic [7:0]        bval_r, bval_nxt;
  rfp_pkg::result_t  res_q [2];
  rfp_pkg::result_t  res_new;
  logic              owr_r, ord_r;
  logic [1:0]        ocnt_r, ocnt_nxt;
  logic              take, do_opop;

  assign take      = ~cmd_empty & (ocnt_r != 2'd2);
  assign cmd_pop   = take;
  assign out_empty = (ocnt_r == 2'd0);
  assign do_opop   = out_pop & ~out_empty;
  assign out_res   = res_q[ord_r];

  // value register update
  always_comb begin
    dist_nxt  = dist_r;
    heart_nxt = heart_r;
    brate_nxt = brate_r;
    bval_nxt  = bval_r;
    unique case (cmd_entry.kind)
      rfp_pkg::UPD_NONE: begin
      end
      rfp_pkg::UPD_DIST: begin
        dist_nxt = cmd_entry.data;
        // nobody present clears everything
        if (cmd_entry.data == 16'd0) begin
          heart_nxt = 8'h00;
          brate_nxt = 8'h00;
          bval_nxt  = 8'h00;
        end
      end
      rfp_pkg::UPD_HEART: heart_nxt = cmd_entry.data[7:0];
      rfp_pkg::UPD_BRATE: brate_nxt = cmd_entry.data[7:0];
      rfp_pkg::UPD_BVAL:  bval_nxt  = cmd_entry.data[7:0];
      default: begin
      end
    endcase
    res_new.distance     = dist_nxt;
    res_new.pulse_rate   = heart_nxt;
    res_new.breath_rate  = brate_nxt;
    res_new.breath_value = bval_nxt;
    res_new.frame_done   = cmd_entry.done;
  end

  // result queue occupancy
  always_comb begin
    ocnt_nxt = ocnt_r;
    if (take && !do_opop) begin
      ocnt_nxt = ocnt_r + 2'd1;
    end else if (do_opop && !take) begin
      ocnt_nxt = ocnt_r - 2'd1;
    end
  end

  // value registers and result pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dist_r  <= 16'd0;
      heart_r <= 8'h00;
      brate_r <= 8'h00;
      bval_r  <= 8'h00;
      owr_r   <= 1'b0;
      ord_r   <= 1'b0;
      ocnt_r  <= 2'd0;
    end else begin
      if (take) begin
        dist_r  <= dist_nxt;
        heart_r <= heart_nxt;
        brate_r <= brate_nxt;
        bval_r  <= bval_nxt;
        owr_r   <= ~owr_r;
      end
      if (do_opop) begin
        ord_r <= ~ord_r;
      end
      ocnt_r <= ocnt_nxt;
    end
  end

  // result storage
  always_ff @(posedge clk) begin
    if (take) begin
      res_q[owr_r] <= res_new;
    end
  end

endmodule

`default_nettype wire

// ----- sv/radar_frame_parser_unit.sv -----
// an accepted word is registered into the update queue, then the value update writes its result into the result queue
// throughput: one word per cycle, set by the parser state update
// the parser stalls only when the four-word update queue is full
// the result side holds up to two words before it backs up into the queue
// reset (rst_n low, synchronous) returns to sync hunt and clears all values
// ------------------------------------------------------------------
// radar_frame_parser_unit
// byte-serial sync/length/checksum frame parser for a radar sensor link
// ------------------------------------------------------------------
`default_nettype none

module radar_frame_parser_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [7:0]  in_rx_byte,
  input  wire logic        out_pop,
  output logic             out_empty,
  output logic [15:0]      out_distance,
  output logic [7:0]       out_pulse_rate,
  output logic [7:0]       out_breath_rate,
  output logic [7:0]       out_breath_value,
  output logic             out_frame_done
);

  rfp_pkg::cmd_entry_t front_entry;
  rfp_pkg::cmd_entry_t back_entry;
  rfp_pkg::result_t    res;
  logic                front_push;
  logic                cmd_full;
  logic                cmd_empty;
  logic                cmd_pop;

  assign in_full = cmd_full;

  // parser and classifier
  rfp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_rx_byte (in_rx_byte),
    .cmd_full   (cmd_full),
    .cmd_push   (front_push),
    .cmd_entry  (front_entry)
  );

  // decoupling queue
  rfp_cmd_fifo u_cmd_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (front_push),
    .entry_in  (front_entry),
    .full      (cmd_full),
    .pop       (cmd_pop),
    .entry_out (back_entry),
    .empty     (cmd_empty)
  );

  // value update and result queue
  rfp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_entry (back_entry),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_res   (res)
  );

  assign out_distance     = res.distance;
  assign out_pulse_rate   = res.pulse_rate;
  assign out_breath_rate  = res.breath_rate;
  assign out_breath_value = res.breath_value;
  assign out_frame_done   = res.frame_done;

endmodule

`default_nettype wire

// ----- sv/rfp_checker.sv -----
// ------------------------------------------------------------------
// rfp_checker
// port-level checks on the radar frame parser, bound to the top level
// ------------------------------------------------------------------
`default_nettype none

`include "radar_frame_parser_unit_macros.svh"

module rfp_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_push,
  input wire logic        in_full,
  input wire logic        out_pop,
  input wire logic        out_empty,
  input wire logic [15:0] out_distance,
  input wire logic        out_frame_done
);

  // the result queue comes out of reset empty and the update queue not full
  `RFP_ASSERT_IMP(a_rst_out_empty, clk, rst_n, $rose(rst_n), out_empty)
  `RFP_ASSERT_IMP(a_rst_in_open, clk, rst_n, $rose(rst_n), !in_full)

  // a result only appears after a word went in and passed through the update queue
  `RFP_ASSERT_IMP(a_result_latency, clk, rst_n, $fell(out_empty), $past(in_push && !in_full, 2))

  // a waiting result holds until taken
  `RFP_ASSERT_NXT(a_result_hold, clk, rst_n, !out_empty && !out_pop, !out_empty && $stable(out_distance) && $stable(out_frame_done))

endmodule

bind radar_frame_parser_unit rfp_checker u_rfp_checker (.*);

`default_nettype wire
